// ===== rtl/bfie_pkg.sv =====
package bfie_pkg;

   localparam int BUF_BYTES      = 64;
   localparam int MAX_FIELD_BITS = 32;
   localparam int BYTE_BITS      = 8;

   localparam int ADDR_W    = $clog2(BUF_BYTES);
   localparam int VALUE_W   = 32;
   localparam int BITS_W    = 6;
   localparam int OFFSET_W  = 9;
   localparam int NEXT_W    = 10;
   localparam int WIN_BYTES = 5;
   localparam int WIN_W     = WIN_BYTES * BYTE_BITS;
   localparam int IDX_W     = 3;

   localparam logic [NEXT_W-1:0] BUF_BITS_L  = NEXT_W'(BUF_BYTES * BYTE_BITS);
   localparam logic [BITS_W-1:0] MAX_BITS_L  = BITS_W'(MAX_FIELD_BITS);
   localparam logic [BITS_W-1:0] VALUE_W_L   = BITS_W'(VALUE_W);
   localparam logic [BITS_W-1:0] WIN_W_L     = BITS_W'(WIN_W);

   localparam logic ACT_INSERT  = 1'b0;
   localparam logic ACT_EXTRACT = 1'b1;

   typedef struct packed {
      logic             load;
      logic             step;
      logic             last;
      logic             skip_done;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic             skip;
      logic [IDX_W-1:0] nbytes;
   } sts_type;

endpackage

// ===== rtl/bfie_ctrl.sv =====
module bfie_ctrl
   import bfie_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd           = '0;
      cmd.idx       = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.skip) begin
               cmd.skip_done = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
               if (idx_ff == sts.nbytes - IDX_W'(1)) begin
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   a_idx_in_span: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (cmd.idx < sts.nbytes))
      else $error("byte index ran past the field span");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not start work");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.last || cmd.skip_done) |=> !busy)
      else $error("controller stayed busy after finishing");

endmodule

// ===== rtl/bfie_datapath.sv =====
module bfie_datapath
   import bfie_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                req_action,
   input  logic [VALUE_W-1:0]  req_field_value,
   input  logic [BITS_W-1:0]   req_field_bits,
   input  logic [OFFSET_W-1:0] req_bit_offset,
   output logic                rsp_strobe,
   output logic [NEXT_W-1:0]   rsp_next_offset,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic                rsp_range_error
);

   logic [BYTE_BITS-1:0] mem [BUF_BYTES];
   logic [BUF_BYTES-1:0] valid_ff;
   logic [BYTE_BITS-1:0] rdata_ff;
   logic                 rvld_ff;

   logic                 action_ff;
   logic [WIN_W-1:0]     ins_ff;
   logic [VALUE_W-1:0]   mask_ff;
   logic [2:0]           end_bit_ff;
   logic [IDX_W-1:0]     nbytes_ff;
   logic [ADDR_W-1:0]    base_ff;
   logic                 skip_ff;
   logic                 err_ff;
   logic [NEXT_W-1:0]    next_ff;
   logic [VALUE_W-1:0]   acc_ff;

   logic                 rsp_strobe_ff;
   logic [NEXT_W-1:0]    rsp_next_ff;
   logic [VALUE_W-1:0]   rsp_read_ff;
   logic                 rsp_err_ff;

   logic [2:0]           start_bit;
   logic [6:0]           span;
   logic [NEXT_W-1:0]    end_sum;
   logic                 err_w;
   logic [VALUE_W-1:0]   mask_w;
   logic [BITS_W-1:0]    shift_w;
   logic [WIN_W-1:0]     ins_w;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 wr_en;
   logic [BYTE_BITS-1:0] byte_rd;
   logic [BYTE_BITS-1:0] wr_data;
   logic [WIN_W-1:0]     ext_win;
   logic [VALUE_W-1:0]   ext_value;

   // Decode the field placement from the request beat.
   always_comb begin
      start_bit = req_bit_offset[2:0];
      span      = 7'({4'b0, start_bit} + {1'b0, req_field_bits} - 7'd1);
      end_sum   = {1'b0, req_bit_offset} + NEXT_W'(req_field_bits);
      err_w     = (req_field_bits > MAX_BITS_L) || (end_sum > BUF_BITS_L);
      mask_w    = {VALUE_W{1'b1}} >> (VALUE_W_L - req_field_bits);
      // Place the field in a five-byte window starting at its first byte, at its bit offset in that byte.
      shift_w   = WIN_W_L - {3'b0, start_bit} - req_field_bits;
      ins_w     = {{(WIN_W-VALUE_W){1'b0}}, req_field_value & mask_w} << shift_w;
   end

   assign rd_addr = cmd.load ? req_bit_offset[OFFSET_W-1:3]
                             : base_ff + ADDR_W'(cmd.idx) + ADDR_W'(1);
   assign wr_addr = base_ff + ADDR_W'(cmd.idx);
   assign wr_en   = cmd.step && (action_ff == ACT_INSERT);
   assign byte_rd = rvld_ff ? rdata_ff : '0;
   assign wr_data = byte_rd | ins_ff[WIN_W-1 -: BYTE_BITS];

   // The last byte holds the field's final bit at end_bit_ff; drop the bits after it.
   assign ext_win   = {acc_ff, byte_rd} >> (3'd7 - end_bit_ff);
   assign ext_value = ext_win[VALUE_W-1:0] & mask_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rvld_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff  <= req_action;
         ins_ff     <= ins_w;
         mask_ff    <= mask_w;
         end_bit_ff <= span[2:0];
         nbytes_ff  <= span[5:3] + IDX_W'(1);
         base_ff    <= req_bit_offset[OFFSET_W-1:3];
         skip_ff    <= err_w || (req_field_bits == '0);
         err_ff     <= err_w;
         next_ff    <= err_w ? {1'b0, req_bit_offset} : end_sum;
         acc_ff     <= '0;
      end else if (cmd.step) begin
         ins_ff <= ins_ff << BYTE_BITS;
         acc_ff <= {acc_ff[VALUE_W-BYTE_BITS-1:0], byte_rd};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.last || cmd.skip_done;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.last || cmd.skip_done) begin
         rsp_next_ff <= next_ff;
         rsp_err_ff  <= err_ff;
         rsp_read_ff <= (cmd.last && (action_ff == ACT_EXTRACT)) ? ext_value : '0;
      end
   end

   assign sts.skip        = skip_ff;
   assign sts.nbytes      = nbytes_ff;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_next_offset = rsp_next_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_range_error = rsp_err_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_range_error) |-> (rsp_read_value == '0))
      else $error("refused field returned data");

   a_no_write_on_skip: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.last) |-> !skip_ff)
      else $error("buffer touched by a refused or empty field");

endmodule

// ===== rtl/bit_field_insert_extract.sv =====
// MSB-first bit field insert/extract over a 64-byte frame buffer that reads
// as all zero after reset. A request beat is taken when start is high and
// busy is low. An empty or refused field leaves the buffer untouched; any
// other field spans N (1 to 5) buffer bytes, and each byte takes one step:
// a read-modify-write on the single write port of the buffer memory for
// an insert, or a plain read for an extract. The result is presented for
// exactly one cycle with rsp_strobe high, in the cycle busy falls; the
// receiver cannot stall it and must capture it then. A new request may be
// accepted in that same cycle.
module bit_field_insert_extract
   import bfie_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [VALUE_W-1:0]  req_field_value,
   input  logic [BITS_W-1:0]   req_field_bits,
   input  logic [OFFSET_W-1:0] req_bit_offset,
   output logic                rsp_strobe,
   output logic [NEXT_W-1:0]   rsp_next_offset,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic                rsp_range_error
);

   cmd_type cmd;
   sts_type sts;

   bfie_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   bfie_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_field_value (req_field_value),
      .req_field_bits  (req_field_bits),
      .req_bit_offset  (req_bit_offset),
      .rsp_strobe      (rsp_strobe),
      .rsp_next_offset (rsp_next_offset),
      .rsp_read_value  (rsp_read_value),
      .rsp_range_error (rsp_range_error)
   );

endmodule
